// File: hw/rtl/radar_glitch_history_filter_defines.svh
// Assertion macros shared by the radar glitch history filter.
`ifndef RADAR_GLITCH_HISTORY_FILTER_DEFINES_SVH
`define RADAR_GLITCH_HISTORY_FILTER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RGHF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RGHF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/rghf_pkg.sv
// Types and constants shared by the radar glitch history filter.
package rghf_pkg;

  localparam int SEL_W  = 2;   // wide enough for up to four sensors
  localparam int SLOT_W = 4;   // wide enough for up to sixteen slots
  localparam int RANGE_W = 16;
  localparam int BEAR_W  = 16;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DIST_TOL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT = 2'd2;

  localparam logic [RANGE_W-1:0] DIST_TOL_RESET  = 16'd100;
  localparam logic [BEAR_W-1:0]  ANGLE_TOL_RESET = 16'd500;
  localparam logic [TIME_W-1:0]  AGE_LIMIT_RESET = 32'd1000;

  // A reading travelling along the compare chain.
  typedef struct packed {
    logic               valid;
    logic [SEL_W-1:0]   sensor;
    logic [RANGE_W-1:0] range_cm;
    logic [BEAR_W-1:0]  bearing;
    logic [TIME_W-1:0]  stamp;
    logic               match;
  } token_t;

  // Broadcast update of one history slot.
  typedef struct packed {
    logic               en;
    logic [SEL_W-1:0]   sensor;
    logic [SLOT_W-1:0]  slot;
    logic [RANGE_W-1:0] range_cm;
    logic [BEAR_W-1:0]  bearing;
    logic [TIME_W-1:0]  stamp;
  } hist_wr_t;

  // Matching thresholds.
  typedef struct packed {
    logic [RANGE_W-1:0] distance;
    logic [BEAR_W-1:0]  angle;
    logic [TIME_W-1:0]  age;
  } tol_t;

endpackage

// File: hw/rtl/radar_glitch_history_filter.sv
// A reading walks the slot chain, one register per cell, before its result is loaded.
// Only one reading is in the chain at a time; a new one waits while the block is busy.
// The next reading may enter on the cycle after the previous result leaves the chain,
// so that it is compared with the history as updated by that result.
// Reset (rst, synchronous) zeroes every history slot, fill level and oldest pointer,
// and loads the tolerances with 100 cm, 500 centidegrees and 1000 ms.
module radar_glitch_history_filter #(
  parameter int ENTRIES = 5,
  parameter int SENSORS = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          sensor_select,
  input  logic [rghf_pkg::RANGE_W-1:0]  range_cm,
  input  logic [rghf_pkg::BEAR_W-1:0]   bearing_centideg,
  input  logic [rghf_pkg::TIME_W-1:0]   now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          is_glitch,
  input  logic                          cfg_write,
  input  logic [rghf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rghf_pkg::CFG_W-1:0]    cfg_data
);
  import rghf_pkg::*;

  localparam int SW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW = $clog2(ENTRIES + 1);
  localparam logic [FW-1:0] FULL     = FW'(ENTRIES);
  localparam logic [EW-1:0] LAST_IDX = EW'(ENTRIES - 1);

  // Matching thresholds; the user must write them only while the block is idle (not enforced).
  tol_t tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol.distance <= DIST_TOL_RESET;
      tol.angle    <= ANGLE_TOL_RESET;
      tol.age      <= AGE_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DIST_TOL:  tol.distance <= cfg_data[RANGE_W-1:0];
        REG_ANGLE_TOL: tol.angle    <= cfg_data[BEAR_W-1:0];
        REG_AGE_LIMIT: tol.age      <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // The chain carries one reading at a time. Each cell compares it with its
  // own slot for the selected sensor and ORs the outcome into the match flag
  // before handing the reading to its neighbour on the next cycle.
  token_t   chain [ENTRIES+1];
  hist_wr_t wr;
  logic     busy;
  logic     load;
  logic     advance;
  logic     accept;

  // A finished reading leaves the last cell once the output register is free.
  // The input stays stalled until the history write of the previous reading has
  // landed, since the first cell compares in the very cycle of acceptance.
  assign load    = chain[ENTRIES].valid && (!out_valid || !out_stall);
  assign advance = !chain[ENTRIES].valid || load;
  assign in_stall = busy;
  assign accept  = in_valid && !in_stall;

  always_comb begin
    chain[0]          = '0;
    chain[0].valid    = accept;
    chain[0].sensor   = (SENSORS > 1) ? SEL_W'(sensor_select) : '0;
    chain[0].range_cm = range_cm;
    chain[0].bearing  = bearing_centideg;
    chain[0].stamp    = now_ms;
    chain[0].match    = 1'b0;
  end

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    rghf_cell #(
      .SENSORS (SENSORS),
      .SLOT    (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tol     (tol),
      .wr      (wr),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

  // Per-sensor allocation state: how many slots are filled, and which slot
  // is overwritten next once the history is full.
  logic [FW-1:0] fill_level  [SENSORS];
  logic [EW-1:0] oldest_slot [SENSORS];
  logic [SW-1:0] sidx;
  logic          full;
  logic          glitch;

  assign sidx   = chain[ENTRIES].sensor[SW-1:0];
  assign full   = (fill_level[sidx] == FULL);
  assign glitch = !chain[ENTRIES].match && full;

  // An unmatched reading is written back into the history as it leaves.
  always_comb begin
    wr.en       = load && !chain[ENTRIES].match;
    wr.sensor   = chain[ENTRIES].sensor;
    wr.slot     = full ? SLOT_W'(oldest_slot[sidx]) : SLOT_W'(fill_level[sidx]);
    wr.range_cm = chain[ENTRIES].range_cm;
    wr.bearing  = chain[ENTRIES].bearing;
    wr.stamp    = chain[ENTRIES].stamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SENSORS; i++) begin
        fill_level[i]  <= '0;
        oldest_slot[i] <= '0;
      end
    end else if (wr.en) begin
      if (!full) begin
        fill_level[sidx] <= fill_level[sidx] + FW'(1);
      end else if (oldest_slot[sidx] == LAST_IDX) begin
        oldest_slot[sidx] <= '0;
      end else begin
        oldest_slot[sidx] <= oldest_slot[sidx] + EW'(1);
      end
    end
  end

  // Busy runs from the accepted transaction until its result is loaded.
  logic busy_next;

  always_comb begin
    busy_next = busy;
    if (load) begin
      busy_next = 1'b0;
    end
    if (accept) begin
      busy_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
  end

  // Output register: holds the result until its transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_glitch <= glitch;
    end
  end

`include "radar_glitch_history_filter_defines.svh"

  `RGHF_ASSERT_NEXT(a_accept_sets_busy, accept, busy, "accepted reading did not mark the block busy")
  `RGHF_ASSERT_NOW(a_chain_end_busy, chain[ENTRIES].valid, busy, "reading at chain end while idle")
  `RGHF_ASSERT_NOW(a_wr_slot_range, wr.en, wr.slot <= SLOT_W'(ENTRIES - 1), "history write outside slot range")
  `RGHF_ASSERT_NEXT(a_load_shows_result, load, out_valid, "loaded result not presented")

endmodule

// File: hw/rtl/rghf_cell.sv
// One history slot per sensor, with its compare stage in the chain.
module rghf_cell #(
  parameter int SENSORS = 2,
  parameter int SLOT    = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  rghf_pkg::tol_t    tol,
  input  rghf_pkg::hist_wr_t wr,
  input  rghf_pkg::token_t  tok_in,
  output rghf_pkg::token_t  tok_out
);
  import rghf_pkg::*;

  localparam int SW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(SLOT);

  logic [RANGE_W-1:0] hist_range   [SENSORS];
  logic [BEAR_W-1:0]  hist_bearing [SENSORS];
  logic [TIME_W-1:0]  hist_stamp   [SENSORS];

  logic [SW-1:0]      rd_idx;
  logic [SW-1:0]      wr_idx;
  logic [RANGE_W-1:0] d_range;
  logic [BEAR_W-1:0]  d_bear;
  logic [TIME_W-1:0]  age;
  logic               hit;
  token_t             tok_next;

  assign rd_idx = tok_in.sensor[SW-1:0];
  assign wr_idx = wr.sensor[SW-1:0];

  always_comb begin
    d_range = (tok_in.range_cm >= hist_range[rd_idx]) ?
              tok_in.range_cm - hist_range[rd_idx] : hist_range[rd_idx] - tok_in.range_cm;
    d_bear  = (tok_in.bearing >= hist_bearing[rd_idx]) ?
              tok_in.bearing - hist_bearing[rd_idx] : hist_bearing[rd_idx] - tok_in.bearing;
    age     = tok_in.stamp - hist_stamp[rd_idx];
    hit     = (d_range <= tol.distance) && (d_bear <= tol.angle) && (age <= tol.age);
    tok_next       = tok_in;
    tok_next.match = tok_in.match | hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

  // The history resets to zero; unfilled slots take part in the compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SENSORS; i++) begin
        hist_range[i]   <= '0;
        hist_bearing[i] <= '0;
        hist_stamp[i]   <= '0;
      end
    end else if (wr.en && (wr.slot == MY_SLOT)) begin
      hist_range[wr_idx]   <= wr.range_cm;
      hist_bearing[wr_idx] <= wr.bearing;
      hist_stamp[wr_idx]   <= wr.stamp;
    end
  end

endmodule

// File: tb/tb_radar_glitch_history_filter.sv
`timescale 1ns / 1ps
// Self-checking testbench for the radar glitch history filter.
module tb_radar_glitch_history_filter;
  import rghf_pkg::*;

  localparam int ENTRIES = 5;
  localparam int SENSORS = 2;
  localparam int HALF_PERIOD_NS = 6;
  localparam int RESET_CYCLES = 5;
  // Quiet cycles once every result is back, before the registers are touched.
  localparam int SETTLE_CYCLES = ENTRIES + 3;
  // Length of the long receiver hold-off that makes the block back up.
  localparam int LONG_HOLD_CYCLES = 120;
  // Cycles without any transaction before the run is declared hung.
  localparam int STUCK_LIMIT = 4000;
  localparam int PHASE_ITEMS = 150;
  localparam int DIRECTED_ROWS = 18;
  localparam int PHASES = 7;
  // An index past the register list; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 sensor_select;
  logic [RANGE_W-1:0]   range_cm;
  logic [BEAR_W-1:0]    bearing_centideg;
  logic [TIME_W-1:0]    now_ms;
  logic                 out_valid;
  logic                 out_stall;
  logic                 is_glitch;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  radar_glitch_history_filter #(
    .ENTRIES(ENTRIES),
    .SENSORS(SENSORS)
  ) u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sensor_select   (sensor_select),
    .range_cm        (range_cm),
    .bearing_centideg(bearing_centideg),
    .now_ms          (now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .is_glitch       (is_glitch),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the filter: per-sensor history, fill counts, eviction pointers and
  // the three thresholds as the testbench last programmed them.
  // ---------------------------------------------------------------------------
  logic [RANGE_W-1:0] hist_rng  [SENSORS][ENTRIES];
  logic [BEAR_W-1:0]  hist_brg  [SENSORS][ENTRIES];
  logic [TIME_W-1:0]  hist_time [SENSORS][ENTRIES];
  int unsigned        fill_count [SENSORS];
  int unsigned        evict_ptr  [SENSORS];
  logic [RANGE_W-1:0] tol_dist;
  logic [BEAR_W-1:0]  tol_angle;
  logic [TIME_W-1:0]  tol_age;

  // Glitch flags still owed by the block, oldest first.
  logic pending_glitch [$];
  int   mismatch_count;
  logic owed_flag;

  // Idling controls, changed by the stimulus between phases.
  int send_idle_pct;
  int stall_pct;
  bit long_hold;

  // Millisecond clock for the random readings, advanced as each one is built.
  logic [TIME_W-1:0] clock_ms;

  typedef struct packed {
    logic               sel;
    logic [RANGE_W-1:0] rng;
    logic [BEAR_W-1:0]  brg;
    logic [TIME_W-1:0]  now;
    bit                 typed;   // the flag below is known by inspection
    logic               glitch;
  } probe_t;

  // Directed readings, applied straight after reset with the reset thresholds of
  // 100 cm, 500 centidegrees and 1000 ms. The front history is filled to the brim
  // one slot at a time.
  probe_t directed_rows [DIRECTED_ROWS] = '{
    // All-zero reading matches the never-written slots.
    '{1'b0, 16'd0,     16'd0,     32'd0,          1'b1, 1'b0},
    // Every difference sits exactly on its threshold, so it still matches.
    '{1'b0, 16'd100,   16'd500,   32'd1000,       1'b1, 1'b0},
    // Just outside on range, then bearing, then age; each is stored while filling.
    '{1'b0, 16'd101,   16'd0,     32'd0,          1'b1, 1'b0},
    '{1'b0, 16'd0,     16'd501,   32'd0,          1'b1, 1'b0},
    '{1'b0, 16'd0,     16'd0,     32'd1001,       1'b1, 1'b0},
    '{1'b0, 16'hFFFF,  16'd35999, 32'hFFFF_FFFF,  1'b1, 1'b0},
    // Bearing above the legal angle is compared as it stands; fills the last slot.
    '{1'b0, 16'hFFFF,  16'hFFFF,  32'hFFFF_FFFF,  1'b1, 1'b0},
    // History is full and nothing is close: a glitch that evicts the oldest slot.
    '{1'b0, 16'd30000, 16'd20000, 32'd500,        1'b1, 1'b1},
    // The clock has wrapped since the last slot was stamped; the age stays small.
    '{1'b0, 16'hFFFF,  16'hFFFF,  32'h0000_0100,  1'b0, 1'b0},
    // The rear history is untouched by all of the above.
    '{1'b1, 16'd0,     16'd0,     32'd0,          1'b1, 1'b0},
    '{1'b1, 16'd40000, 16'd30000, 32'd5000,       1'b1, 1'b0},
    '{1'b1, 16'd40100, 16'd30500, 32'd6000,       1'b0, 1'b0},
    // The replacement written by the glitch above is now matched.
    '{1'b0, 16'd30000, 16'd20000, 32'd500,        1'b0, 1'b0},
    '{1'b0, 16'd12345, 16'd1234,  32'd700,        1'b1, 1'b1},
    '{1'b1, 16'd60000, 16'd35999, 32'h8000_0000,  1'b0, 1'b0},
    '{1'b0, 16'd0,     16'd35999, 32'h7FFF_FFFF,  1'b0, 1'b0},
    // Alternating bit patterns so that every range, bearing and time bit is seen at both levels.
    '{1'b1, 16'hAAAA,  16'h5555,  32'hAAAA_AAAA,  1'b0, 1'b0},
    '{1'b1, 16'h5555,  16'hAAAA,  32'h5555_5555,  1'b0, 1'b0}
  };

  typedef struct packed {
    logic [RANGE_W-1:0] distance;
    logic [BEAR_W-1:0]  angle;
    logic [TIME_W-1:0]  age;
    int                 send_pct;
    int                 stall_pct;
    bit                 squeeze;    // long receiver hold-off at the start
    bit                 shuffle;    // thresholds drawn at random instead
  } phase_t;

  // Random phases: the threshold settings include both extremes, and the idling
  // modes cover no idling, an idle sender, a stalling receiver and both lightly.
  phase_t phases [PHASES] = '{
    '{16'd300,   16'd800,   32'd2000,      0,  0,  1'b0, 1'b0},
    '{16'd0,     16'd0,     32'd0,         45, 0,  1'b0, 1'b0},
    '{16'hFFFF,  16'd36000, 32'hFFFF_FFFF, 0,  45, 1'b0, 1'b0},
    '{16'd1000,  16'd2000,  32'd500,       8,  8,  1'b0, 1'b0},
    '{16'd50,    16'd100,   32'd3000,      0,  0,  1'b1, 1'b0},
    '{16'd0,     16'd0,     32'd0,         0,  45, 1'b0, 1'b1},
    '{16'hFFFF,  16'hFFFF,  32'd0,         8,  8,  1'b0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #(HALF_PERIOD_NS) clk = ~clk;
  end

  function automatic logic [15:0] gap16(input logic [15:0] a, input logic [15:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Works out the glitch flag for one accepted reading and updates the shadow
  // history exactly as the filter should.
  function automatic logic screen_reading(input logic sel, input logic [RANGE_W-1:0] rng,
                                          input logic [BEAR_W-1:0] brg,
                                          input logic [TIME_W-1:0] now);
    int          s;
    int unsigned slot;
    bit          hit;
    logic        flag;
    logic [TIME_W-1:0] age;
    s = int'(sel) % SENSORS;
    hit = 1'b0;
    flag = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      // Unsigned difference, so a wrapped clock still gives the true age.
      age = now - hist_time[s][i];
      if (gap16(rng, hist_rng[s][i]) <= tol_dist && gap16(brg, hist_brg[s][i]) <= tol_angle
          && age <= tol_age) begin
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (fill_count[s] < ENTRIES) begin
        slot = fill_count[s];
        fill_count[s]++;
      end else begin
        slot = evict_ptr[s] % ENTRIES;
        evict_ptr[s] = (slot + 1) % ENTRIES;
        flag = 1'b1;
      end
      hist_rng[s][slot] = rng;
      hist_brg[s][slot] = brg;
      hist_time[s][slot] = now;
    end
    return flag;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] result check failed: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offers one reading and holds it until the filter takes it. The sender may sit
  // idle for a while first; valid is only ever lowered in a cycle of its own.
  task automatic offer_reading(input logic sel, input logic [RANGE_W-1:0] rng,
                               input logic [BEAR_W-1:0] brg, input logic [TIME_W-1:0] now,
                               input bit typed, input logic typed_glitch);
    logic predicted;
    while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    sensor_select    <= sel;
    range_cm         <= rng;
    bearing_centideg <= brg;
    now_ms           <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // The transaction has just gone in at this edge.
    predicted = screen_reading(sel, rng, brg, now);
    pending_glitch.push_back(typed ? typed_glitch : predicted);
  endtask

  // Drops valid, waits for every owed result and lets the chain empty out.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_glitch.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the three thresholds back to back, with junk in the unused upper data
  // bits, and optionally a write to the spare index that must change nothing.
  task automatic load_tolerances(input logic [RANGE_W-1:0] distance,
                                 input logic [BEAR_W-1:0] angle,
                                 input logic [TIME_W-1:0] age, input bit poke_spare);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_W-1:0]     val [4];
    int                   n;
    idx = '{REG_DIST_TOL, REG_ANGLE_TOL, REG_AGE_LIMIT, REG_SPARE};
    val = '{{16'($urandom()), distance}, {16'($urandom()), angle}, age, $urandom()};
    n = poke_spare ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    tol_dist  = distance;
    tol_angle = angle;
    tol_age   = age;
  endtask

  // A value at, just beyond, inside or far from the given threshold around centre.
  function automatic logic [15:0] near_value(input logic [15:0] centre, input logic [15:0] tol);
    logic [16:0] off;
    case ($urandom_range(0, 3))
      0: off = {1'b0, tol};
      1: off = {1'b0, tol} + 17'd1;
      2: off = 17'($urandom_range(0, tol));
      default: off = 17'($urandom_range(0, 65535));
    endcase
    return $urandom_range(0, 1) ? centre + off[15:0] : centre - off[15:0];
  endfunction

  // Builds and offers one random reading. Most readings are aimed at a stored
  // slot so that matches and near misses are common; the rest are either wild
  // values or small ones that meet the zeroed slots of a fresh history.
  task automatic offer_random_reading();
    logic               sel;
    logic [RANGE_W-1:0] rng;
    logic [BEAR_W-1:0]  brg;
    logic [TIME_W-1:0]  now;
    int                 k;
    int                 pick;
    sel = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 5) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, 50);
    now = clock_ms;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      k = $urandom_range(0, ENTRIES - 1);
      rng = near_value(hist_rng[sel][k], tol_dist);
      brg = near_value(hist_brg[sel][k], tol_angle);
      if ($urandom_range(0, 3) == 0) now = hist_time[sel][k] + tol_age + $urandom_range(0, 1);
    end else if (pick < 80) begin
      rng = 16'($urandom());
      brg = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 35999));
      if ($urandom_range(0, 1)) now = $urandom();
    end else begin
      rng = 16'($urandom_range(0, 300));
      brg = 16'($urandom_range(0, 700));
      if ($urandom_range(0, 1)) now = $urandom_range(0, 2000);
    end
    offer_reading(sel, rng, brg, now, 1'b0, 1'b0);
  endtask

  // Receiver: random stalls, or one long hold-off when the stimulus asks for it.
  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else begin
        out_stall <= (stall_pct != 0) && ($urandom_range(1, 100) <= stall_pct);
      end
    end
  end

  // Every result transaction is checked against the oldest owed flag.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_glitch.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed, is_glitch=%b", is_glitch));
      end else begin
        owed_flag = pending_glitch.pop_front();
        if (is_glitch !== owed_flag) begin
          report_mismatch($sformatf("is_glitch=%b, wanted %b", is_glitch, owed_flag));
        end
      end
    end
  end

  // Hang detector: counts cycles with no transaction on either side.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    phase_t ph;
    rst              <= 1'b1;
    in_valid         <= 1'b0;
    sensor_select    <= 1'b0;
    range_cm         <= '0;
    bearing_centideg <= '0;
    now_ms           <= '0;
    cfg_write        <= 1'b0;
    cfg_index        <= REG_DIST_TOL;
    cfg_data         <= '0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    long_hold      = 1'b0;
    clock_ms       = '0;

    // The shadow starts from the reset state of the filter.
    tol_dist  = DIST_TOL_RESET;
    tol_angle = ANGLE_TOL_RESET;
    tol_age   = AGE_LIMIT_RESET;
    for (int s = 0; s < SENSORS; s++) begin
      fill_count[s] = 0;
      evict_ptr[s]  = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        hist_rng[s][i]  = '0;
        hist_brg[s][i]  = '0;
        hist_time[s][i] = '0;
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table at the reset thresholds, with no idling on either side.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      offer_reading(directed_rows[r].sel, directed_rows[r].rng, directed_rows[r].brg,
                    directed_rows[r].now, directed_rows[r].typed, directed_rows[r].glitch);
    end

    // Random phases, each behind a quiet point and a fresh set of thresholds.
    for (int p = 0; p < PHASES; p++) begin
      ph = phases[p];
      settle_block();
      if (ph.shuffle) begin
        ph.distance = 16'($urandom_range(0, 2000));
        ph.angle    = 16'($urandom_range(0, 36000));
        ph.age      = $urandom_range(0, 100000);
      end
      load_tolerances(ph.distance, ph.angle, ph.age, p == 0);
      send_idle_pct = ph.send_pct;
      stall_pct     = ph.stall_pct;
      // Odd phases start just short of the clock wrapping round.
      clock_ms = (p % 2) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom_range(0, 3000);
      if (ph.squeeze) long_hold = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) offer_random_reading();
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/rghf_pkg.sv
hw/rtl/rghf_cell.sv
hw/rtl/radar_glitch_history_filter.sv
tb/tb_radar_glitch_history_filter.sv
